FILE: src/tti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_pkg: shared types and constants of the table trilinear interpolator
// Grid sizes, item and result layouts, controller commands and helpers.
// ----------------------------------------------------------------------------
package tti_pkg;

  // Grid sizes
  localparam int N_TEMP   = 35;
  localparam int N_GRAV   = 14;
  localparam int N_ENERGY = 166;
  localparam int N_ANGLE  = 67;

  localparam int TAB_DEPTH = N_TEMP * N_GRAV * N_ENERGY * N_ANGLE;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);
  localparam int ANG_AW    = $clog2(N_ANGLE);
  localparam int ANG_CW    = $clog2(N_ANGLE + 1);
  localparam int T_IW      = $clog2(N_TEMP);
  localparam int G_IW      = $clog2(N_GRAV);

  localparam logic [TAB_AW-1:0] STRIDE_G = TAB_AW'(N_ENERGY * N_ANGLE);
  localparam logic [TAB_AW-1:0] STRIDE_T = TAB_AW'(N_GRAV * N_ENERGY * N_ANGLE);

  // Divider sizing: |dividend| < 2^57, |divisor| < 2^24
  localparam int DVD_W  = 58;
  localparam int DVS_W  = 25;
  localparam int QM_W   = 57;
  localparam int DM_W   = 24;
  localparam int DIV_CW = $clog2(QM_W);

  // Configuration port
  localparam int PADDR_W = 5;

  // Request codes
  localparam logic [1:0] REQ_TAB_WR = 2'd0;
  localparam logic [1:0] REQ_ANG_WR = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_TEMP_ORIGIN = 3'd0;
  localparam logic [2:0] REG_TEMP_STEP   = 3'd1;
  localparam logic [2:0] REG_TEMP_INV    = 3'd2;
  localparam logic [2:0] REG_GRAV_ORIGIN = 3'd3;
  localparam logic [2:0] REG_GRAV_STEP   = 3'd4;
  localparam logic [2:0] REG_GRAV_INV    = 3'd5;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [22:0]        address;
    logic signed [31:0] write_value;
    logic [16:0]        angle_cos;
    logic [23:0]        log_temp;
    logic [23:0]        log_grav;
    logic [7:0]         energy_index;
  } req_t;

  typedef struct packed {
    logic signed [31:0] log_intensity;
    logic               out_of_grid;
  } res_t;

  typedef struct packed {
    logic [23:0] temp_origin;
    logic [23:0] temp_step;
    logic [23:0] temp_step_inv;
    logic [23:0] grav_origin;
    logic [23:0] grav_step;
    logic [23:0] grav_step_inv;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_ACCEPT, OP_SRCH_RD, OP_SRCH_INC, OP_ANG_RD0, OP_ANG_RD1, OP_ANG_SET,
    OP_LOC_MUL, OP_LOC_MUL2, OP_LOC_SUB, OP_LOC_FIX, OP_ADR1, OP_ADR2, OP_ADR3,
    OP_L0, OP_LMUL, OP_DIV, OP_LADD, OP_SAVE_M, OP_SAVE_G, OP_FINISH
  } op_e;

  typedef enum logic [1:0] {
    LS_ANG, LS_GRAV, LS_TEMP
  } lsrc_e;

  typedef struct packed {
    op_e   op;
    logic  trd;
    logic  kt;
    logic  kg;
    logic  m1;
    logic  axis;
    lsrc_e lsrc;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic srch_lt;
    logic srch_last;
    logic use_mu;
    logic dt_nz;
    logic dg_nz;
    logic div_done;
  } sts_t;

  // Clip a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = SAT_MAX[31:0];
    else if (v < SAT_MIN) r = SAT_MIN[31:0];
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: src/tti_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_div: signed restoring divider
// One quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module tti_div import tti_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dvd_i,
  input  logic signed [DVS_W-1:0] dvs_i,
  output logic                    done_o,
  output logic signed [DVD_W-1:0] quo_o
);

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DM_W-1:0]   rem_q;
  logic [QM_W-1:0]   quo_q;
  logic [DM_W-1:0]   dvs_q;
  logic              neg_q;

  logic [DVD_W-1:0] dvd_abs;
  logic [DVS_W-1:0] dvs_abs;
  logic [DM_W:0]    rem_sh;
  logic             ge;

  assign dvd_abs = dvd_i[DVD_W-1] ? DVD_W'(-dvd_i) : DVD_W'(dvd_i);
  assign dvs_abs = dvs_i[DVS_W-1] ? DVS_W'(-dvs_i) : DVS_W'(dvs_i);
  assign rem_sh  = {rem_q, quo_q[QM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};

  // Control: run for one cycle per quotient bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(QM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath: shift in dividend bits, subtract where it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dvd_abs[QM_W-1:0];
      rem_q <= '0;
      dvs_q <= dvs_abs[DM_W-1:0];
      neg_q <= dvd_i[DVD_W-1] ^ dvs_i[DVS_W-1];
    end else if (busy_q) begin
      rem_q <= ge ? DM_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DM_W-1:0];
      quo_q <= {quo_q[QM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

FILE: src/tti_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_datapath: storage and arithmetic of the interpolator
// Holds the intensity table and angle grid, locates grid indices and
// performs each linear interpolation with a shared multiplier and divider.
// ----------------------------------------------------------------------------
module tti_datapath import tti_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t item_i,
  input  cfg_t cfg_i,
  output sts_t sts_o,
  output logic done_o,
  output res_t result_o
);

  // Memories
  logic [31:0] tab_mem [TAB_DEPTH];
  logic [16:0] ang_mem [N_ANGLE];
  logic [31:0] tab_rd_q;
  logic [16:0] ang_rd_q;

  // Query registers
  logic [16:0]             cos_q;
  logic [23:0]             lt_q;
  logic [23:0]             lg_q;
  logic [7:0]              e_q;
  logic                    flag_q;
  logic [ANG_CW-1:0]       n_q;
  logic [16:0]             a_im_q;
  logic [ANG_AW-1:0]       im_q;
  logic signed [17:0]      dmu_q;
  logic signed [17:0]      den_q;
  logic                    use_mu_q;
  logic [47:0]             prod_q;
  logic [15:0]             i_q;
  logic [39:0]             istep_q;
  logic signed [41:0]      d_q;
  logic [T_IW-1:0]         it_q;
  logic [23:0]             dt_q;
  logic [G_IW-1:0]         ig_q;
  logic [23:0]             dg_q;
  logic [TAB_AW-1:0]       r1_q;
  logic [TAB_AW-1:0]       r2_q;
  logic [TAB_AW-1:0]       base_q;
  logic signed [31:0]      lv_q;
  logic signed [31:0]      mv_q [2];
  logic signed [31:0]      gv_q [2];
  logic signed [DVD_W-1:0] lprod_q;
  logic signed [31:0]      lbase_q;
  logic signed [DVS_W-1:0] lden_q;
  logic                    done_q;
  res_t                    res_q;

  // Accept-time decode
  logic accept;
  logic tab_we;
  logic ang_we;
  logic e_big;

  assign accept = cmd_i.op == OP_ACCEPT;
  assign tab_we = accept && item_i.req_type == REQ_TAB_WR
                  && 32'(item_i.address) < 32'(TAB_DEPTH);
  assign ang_we = accept && item_i.req_type == REQ_ANG_WR
                  && 32'(item_i.address) < 32'(N_ANGLE);
  assign e_big  = {1'b0, item_i.energy_index} >= 9'(N_ENERGY);

  // Table port
  logic [TAB_AW-1:0] tab_ra;

  assign tab_ra = base_q + (cmd_i.kt ? STRIDE_T : '0) + (cmd_i.kg ? STRIDE_G : '0)
                  + TAB_AW'(cmd_i.m1);

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[item_i.address[TAB_AW-1:0]] <= item_i.write_value;
    if (cmd_i.trd) tab_rd_q <= tab_mem[tab_ra];
  end

  // Angle grid port
  logic              ang_re;
  logic [ANG_AW-1:0] ang_ra;
  logic              n_in;

  assign n_in = n_q < ANG_CW'(N_ANGLE);

  always_comb begin
    ang_re = 1'b0;
    ang_ra = n_q[ANG_AW-1:0];
    unique case (cmd_i.op)
      OP_SRCH_RD: ang_re = 1'b1;
      OP_ANG_RD0: begin
        ang_re = 1'b1;
        ang_ra = ANG_AW'(n_q - 1'b1);
      end
      OP_ANG_RD1: ang_re = n_in;
      default: ang_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ang_we) ang_mem[item_i.address[ANG_AW-1:0]] <= item_i.write_value[16:0];
    if (ang_re) ang_rd_q <= ang_mem[ang_ra];
  end

  // Angle offset and denominator
  logic               a_last;
  logic signed [17:0] a_dmu;
  logic signed [17:0] a_den;
  logic               a_flag;

  always_comb begin
    a_last = n_q == ANG_CW'(N_ANGLE);
    a_dmu  = $signed({1'b0, cos_q}) - $signed({1'b0, a_im_q});
    a_flag = 1'b0;
    if (a_last && a_dmu != 0) begin
      a_dmu  = '0;
      a_flag = 1'b1;
    end
    a_den = a_last ? 18'sd0 : $signed({1'b0, ang_rd_q}) - $signed({1'b0, a_im_q});
  end

  // Locate operands for the selected axis
  logic [23:0]        x_sel;
  logic [23:0]        org_sel;
  logic [23:0]        step_sel;
  logic [23:0]        inv_sel;
  logic signed [24:0] diff;
  logic signed [17:0] n_last;

  always_comb begin
    if (cmd_i.axis) begin
      x_sel    = lg_q;
      org_sel  = cfg_i.grav_origin;
      step_sel = cfg_i.grav_step;
      inv_sel  = cfg_i.grav_step_inv;
      n_last   = 18'(N_GRAV - 1);
    end else begin
      x_sel    = lt_q;
      org_sel  = cfg_i.temp_origin;
      step_sel = cfg_i.temp_step;
      inv_sel  = cfg_i.temp_step_inv;
      n_last   = 18'(N_TEMP - 1);
    end
    diff = $signed({1'b0, x_sel}) - $signed({1'b0, org_sel});
  end

  // Correct the index once, then clamp index and offset to the grid
  logic signed [17:0] fx_i;
  logic signed [41:0] fx_d;
  logic signed [41:0] fx_s;
  logic               fx_flag;

  always_comb begin
    fx_s    = $signed({18'd0, step_sel});
    fx_i    = $signed({2'b00, i_q});
    fx_d    = d_q;
    fx_flag = 1'b0;
    if (step_sel == '0) begin
      fx_d = '0;
    end else begin
      if (fx_d >= fx_s) begin
        fx_i = fx_i + 18'sd1;
        fx_d = fx_d - fx_s;
      end else if (fx_d < 0) begin
        fx_i = fx_i - 18'sd1;
        fx_d = fx_d + fx_s;
      end
      if (fx_d < 0) fx_d = '0;
      if (fx_d >= fx_s) fx_d = fx_s - 42'sd1;
    end
    if (fx_i < 0) begin
      fx_i    = '0;
      fx_d    = '0;
      fx_flag = 1'b1;
    end
    if (fx_i > n_last || (fx_i == n_last && fx_d != 0)) begin
      fx_i    = n_last;
      fx_d    = '0;
      fx_flag = 1'b1;
    end
    if (diff < 0) begin
      fx_i    = '0;
      fx_d    = '0;
      fx_flag = 1'b1;
    end
  end

  // Interpolation operands
  logic signed [31:0]      l_a;
  logic signed [31:0]      l_b;
  logic signed [DVS_W-1:0] l_num;
  logic signed [DVS_W-1:0] l_den;
  logic signed [32:0]      l_diff;
  logic signed [DVD_W-1:0] l_prod;

  always_comb begin
    unique case (cmd_i.lsrc)
      LS_GRAV: begin
        l_a   = mv_q[0];
        l_b   = mv_q[1];
        l_num = $signed({1'b0, dg_q});
        l_den = $signed({1'b0, cfg_i.grav_step});
      end
      LS_TEMP: begin
        l_a   = gv_q[0];
        l_b   = gv_q[1];
        l_num = $signed({1'b0, dt_q});
        l_den = $signed({1'b0, cfg_i.temp_step});
      end
      default: begin
        l_a   = lv_q;
        l_b   = $signed(tab_rd_q);
        l_num = DVS_W'(dmu_q);
        l_den = DVS_W'(den_q);
      end
    endcase
    l_diff = 33'(l_b) - 33'(l_a);
    l_prod = l_diff * l_num;
  end

  // Shared divider
  logic                    div_done;
  logic signed [DVD_W-1:0] div_quo;

  tti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.op == OP_DIV),
    .dvd_i  (lprod_q),
    .dvs_i  (lden_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Execute commands
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        cos_q  <= item_i.angle_cos;
        lt_q   <= item_i.log_temp;
        lg_q   <= item_i.log_grav;
        e_q    <= e_big ? 8'(N_ENERGY - 1) : item_i.energy_index;
        flag_q <= e_big;
        n_q    <= ANG_CW'(1);
      end
      OP_SRCH_INC: n_q <= n_q + 1'b1;
      OP_ANG_RD1: a_im_q <= ang_rd_q;
      OP_ANG_SET: begin
        im_q     <= ANG_AW'(n_q - 1'b1);
        dmu_q    <= a_dmu;
        den_q    <= a_den;
        use_mu_q <= a_dmu != 0 && a_den != 0;
        if (a_flag) flag_q <= 1'b1;
      end
      OP_LOC_MUL: prod_q <= diff[23:0] * inv_sel;
      OP_LOC_MUL2: begin
        i_q     <= prod_q[47:32];
        istep_q <= prod_q[47:32] * step_sel;
      end
      OP_LOC_SUB: d_q <= 42'(diff) - $signed({2'b00, istep_q});
      OP_LOC_FIX: begin
        if (cmd_i.axis) begin
          ig_q <= G_IW'(fx_i);
          dg_q <= fx_d[23:0];
        end else begin
          it_q <= T_IW'(fx_i);
          dt_q <= fx_d[23:0];
        end
        if (fx_flag) flag_q <= 1'b1;
      end
      OP_ADR1: r1_q <= TAB_AW'(TAB_AW'(it_q) * TAB_AW'(N_GRAV) + TAB_AW'(ig_q));
      OP_ADR2: r2_q <= TAB_AW'(r1_q * TAB_AW'(N_ENERGY) + TAB_AW'(e_q));
      OP_ADR3: base_q <= TAB_AW'(r2_q * TAB_AW'(N_ANGLE) + TAB_AW'(im_q));
      OP_L0: lv_q <= $signed(tab_rd_q);
      OP_LMUL: begin
        lprod_q <= l_prod;
        lbase_q <= l_a;
        lden_q  <= l_den;
      end
      OP_LADD: lv_q <= sat32(64'(lbase_q) + 64'(div_quo));
      OP_SAVE_M: mv_q[cmd_i.kg] <= lv_q;
      OP_SAVE_G: gv_q[cmd_i.kt] <= lv_q;
      OP_FINISH: begin
        res_q.log_intensity <= sat32(64'(lv_q) + $signed({39'd0, lt_q, 1'b0})
                                     + $signed({40'd0, lt_q}));
        res_q.out_of_grid   <= flag_q;
      end
      default: ;
    endcase
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= cmd_i.op == OP_FINISH;
  end

  assign sts_o.is_query  = item_i.req_type == REQ_QUERY;
  assign sts_o.srch_lt   = {1'b0, cos_q} < {1'b0, ang_rd_q};
  assign sts_o.srch_last = n_q == ANG_CW'(N_ANGLE - 1);
  assign sts_o.use_mu    = use_mu_q;
  assign sts_o.dt_nz     = dt_q != '0;
  assign sts_o.dg_nz     = dg_q != '0;
  assign sts_o.div_done  = div_done;

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: src/tti_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_ctrl: sequencer of the interpolator
// Steps each query through search, locate, addressing and interpolation.
// ----------------------------------------------------------------------------
module tti_ctrl import tti_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SRCH_RD  = 5'd1;
  localparam logic [4:0] S_SRCH_CMP = 5'd2;
  localparam logic [4:0] S_ANG_RD0  = 5'd3;
  localparam logic [4:0] S_ANG_RD1  = 5'd4;
  localparam logic [4:0] S_ANG_SET  = 5'd5;
  localparam logic [4:0] S_LOC_MUL  = 5'd6;
  localparam logic [4:0] S_LOC_MUL2 = 5'd7;
  localparam logic [4:0] S_LOC_SUB  = 5'd8;
  localparam logic [4:0] S_LOC_FIX  = 5'd9;
  localparam logic [4:0] S_ADR1     = 5'd10;
  localparam logic [4:0] S_ADR2     = 5'd11;
  localparam logic [4:0] S_ADR3     = 5'd12;
  localparam logic [4:0] S_C_RD0    = 5'd13;
  localparam logic [4:0] S_C_RD1    = 5'd14;
  localparam logic [4:0] S_LMUL     = 5'd15;
  localparam logic [4:0] S_DIV      = 5'd16;
  localparam logic [4:0] S_DIV_WAIT = 5'd17;
  localparam logic [4:0] S_LADD     = 5'd18;
  localparam logic [4:0] S_SAVE_M   = 5'd19;
  localparam logic [4:0] S_SAVE_G   = 5'd20;
  localparam logic [4:0] S_FINISH   = 5'd21;

  logic [4:0] state_q, state_d;
  logic       axis_q, axis_d;
  logic       kt_q, kt_d;
  logic       kg_q, kg_d;
  lsrc_e      src_q, src_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= 1'b0;
      kt_q    <= 1'b0;
      kg_q    <= 1'b0;
      src_q   <= LS_ANG;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      kt_q    <= kt_d;
      kg_q    <= kg_d;
      src_q   <= src_d;
    end
  end

  // Next state and command
  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    kt_d       = kt_q;
    kg_d       = kg_q;
    src_d      = src_q;
    cmd_o.op   = OP_NOP;
    cmd_o.trd  = 1'b0;
    cmd_o.kt   = kt_q;
    cmd_o.kg   = kg_q;
    cmd_o.m1   = 1'b0;
    cmd_o.axis = axis_q;
    cmd_o.lsrc = src_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_ACCEPT;
          if (sts_i.is_query) state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        cmd_o.op = OP_SRCH_RD;
        state_d  = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (sts_i.srch_lt) begin
          cmd_o.op = OP_SRCH_INC;
          state_d  = sts_i.srch_last ? S_ANG_RD0 : S_SRCH_RD;
        end else begin
          state_d = S_ANG_RD0;
        end
      end
      S_ANG_RD0: begin
        cmd_o.op = OP_ANG_RD0;
        state_d  = S_ANG_RD1;
      end
      S_ANG_RD1: begin
        cmd_o.op = OP_ANG_RD1;
        state_d  = S_ANG_SET;
      end
      S_ANG_SET: begin
        cmd_o.op = OP_ANG_SET;
        axis_d   = 1'b0;
        state_d  = S_LOC_MUL;
      end
      S_LOC_MUL: begin
        cmd_o.op = OP_LOC_MUL;
        state_d  = S_LOC_MUL2;
      end
      S_LOC_MUL2: begin
        cmd_o.op = OP_LOC_MUL2;
        state_d  = S_LOC_SUB;
      end
      S_LOC_SUB: begin
        cmd_o.op = OP_LOC_SUB;
        state_d  = S_LOC_FIX;
      end
      S_LOC_FIX: begin
        cmd_o.op = OP_LOC_FIX;
        if (axis_q) begin
          state_d = S_ADR1;
        end else begin
          axis_d  = 1'b1;
          state_d = S_LOC_MUL;
        end
      end
      S_ADR1: begin
        cmd_o.op = OP_ADR1;
        state_d  = S_ADR2;
      end
      S_ADR2: begin
        cmd_o.op = OP_ADR2;
        state_d  = S_ADR3;
      end
      S_ADR3: begin
        cmd_o.op = OP_ADR3;
        kt_d     = 1'b0;
        kg_d     = 1'b0;
        state_d  = S_C_RD0;
      end
      // Read the lower angle corner
      S_C_RD0: begin
        cmd_o.trd = 1'b1;
        state_d   = S_C_RD1;
      end
      // Hold the lower corner, fetch the upper one when angle is interpolated
      S_C_RD1: begin
        cmd_o.op  = OP_L0;
        cmd_o.trd = sts_i.use_mu;
        cmd_o.m1  = 1'b1;
        if (sts_i.use_mu) begin
          src_d   = LS_ANG;
          state_d = S_LMUL;
        end else begin
          state_d = S_SAVE_M;
        end
      end
      S_LMUL: begin
        cmd_o.op = OP_LMUL;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        state_d  = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) state_d = S_LADD;
      end
      S_LADD: begin
        cmd_o.op = OP_LADD;
        unique case (src_q)
          LS_GRAV: state_d = S_SAVE_G;
          LS_TEMP: state_d = S_FINISH;
          default: state_d = S_SAVE_M;
        endcase
      end
      S_SAVE_M: begin
        cmd_o.op = OP_SAVE_M;
        if (!kg_q && sts_i.dg_nz) begin
          kg_d    = 1'b1;
          state_d = S_C_RD0;
        end else if (sts_i.dg_nz) begin
          src_d   = LS_GRAV;
          state_d = S_LMUL;
        end else begin
          state_d = S_SAVE_G;
        end
      end
      S_SAVE_G: begin
        cmd_o.op = OP_SAVE_G;
        if (!kt_q && sts_i.dt_nz) begin
          kt_d    = 1'b1;
          kg_d    = 1'b0;
          state_d = S_C_RD0;
        end else if (sts_i.dt_nz) begin
          src_d   = LS_TEMP;
          state_d = S_LMUL;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.op = OP_FINISH;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = state_q != S_IDLE;

endmodule

FILE: src/table_trilinear_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_trilinear_interpolator_top: table trilinear interpolator
// Configuration registers, sequencer and datapath of the interpolator.
// ----------------------------------------------------------------------------
// Table and angle-grid writes are taken while idle and busy stays low.
// A query keeps busy high while a linear search compares one to 66 angle
// grid entries through the angle memory port, the temperature and gravity
// indices are located, the table address is formed, one, two or four
// temperature and gravity corner positions (one or two temperature
// positions) are read on the single table port, both angle corners
// included, and zero to seven interpolations run through the bit-serial
// divider. The result shows on result_o with done_o high for exactly one
// cycle, in the first cycle after busy falls; the receiver cannot stall it,
// so it must take every result as it appears. Both memories power up
// undefined and need no clearing; configuration registers are written and
// read over the APB port; the user must do so only while busy is low, as the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
module table_trilinear_interpolator_top import tti_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  req_t               item_i,
  output logic               done_o,
  output res_t               result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic busy_w;
  logic cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_origin   <= 24'd334234;
      cfg_q.temp_step     <= 24'd3277;
      cfg_q.temp_step_inv <= 24'd1310720;
      cfg_q.grav_origin   <= 24'd897843;
      cfg_q.grav_step     <= 24'd6554;
      cfg_q.grav_step_inv <= 24'd655360;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_TEMP_ORIGIN: cfg_q.temp_origin   <= pwdata[23:0];
        REG_TEMP_STEP:   cfg_q.temp_step     <= pwdata[23:0];
        REG_TEMP_INV:    cfg_q.temp_step_inv <= pwdata[23:0];
        REG_GRAV_ORIGIN: cfg_q.grav_origin   <= pwdata[23:0];
        REG_GRAV_STEP:   cfg_q.grav_step     <= pwdata[23:0];
        REG_GRAV_INV:    cfg_q.grav_step_inv <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[4:2])
      REG_TEMP_ORIGIN: prdata = {8'd0, cfg_q.temp_origin};
      REG_TEMP_STEP:   prdata = {8'd0, cfg_q.temp_step};
      REG_TEMP_INV:    prdata = {8'd0, cfg_q.temp_step_inv};
      REG_GRAV_ORIGIN: prdata = {8'd0, cfg_q.grav_origin};
      REG_GRAV_STEP:   prdata = {8'd0, cfg_q.grav_step};
      REG_GRAV_INV:    prdata = {8'd0, cfg_q.grav_step_inv};
      default:         prdata = '0;
    endcase
  end

  tti_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_w)
  );

  tti_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .item_i  (item_i),
    .cfg_i   (cfg_q),
    .sts_o   (sts),
    .done_o  (done_o),
    .result_o(result_o)
  );

  assign busy = busy_w;

endmodule
